>>> src/csc_pkg.sv
package csc_pkg;

    // digit width of the partial-product multiplier
    localparam int CHUNK_W = 32;

    // which squared distance reaches the root
    typedef enum logic [2:0] {
        SEL_BASE = 3'b001,
        SEL_TIP  = 3'b010,
        SEL_MID  = 3'b100
    } t_sel;

    // one finished result word
    typedef struct packed {
        logic [15:0] normal_x;
        logic [15:0] normal_y;
        logic [15:0] normal_z;
        logic [31:0] gap_depth;
    } t_result;

endpackage

>>> src/csc_dly.sv
module csc_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    // alignment line, advances with the pipeline enable
    generate
        if (DEPTH == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_line
            logic [WIDTH-1:0] r_sh [DEPTH];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sh[0] <= i_d;
                    for (int k = 1; k < DEPTH; k++) begin
                        r_sh[k] <= r_sh[k-1];
                    end
                end
            end
            assign o_q = r_sh[DEPTH-1];
        end
    endgenerate

endmodule

>>> src/csc_mul.sv
module csc_mul
    import csc_pkg::*;
#(
    parameter int AW = 66,
    parameter int BW = 66
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [AW-1:0]   i_a,
    input  logic [BW-1:0]   i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int CW  = CHUNK_W;
    localparam int NA  = (AW + CW - 1) / CW;
    localparam int NB  = (BW + CW - 1) / CW;
    localparam int RWW = (NB + 1) * CW;
    localparam int PW  = (NA + NB) * CW;

    logic [NA*CW-1:0] w_a;
    logic [NB*CW-1:0] w_b;
    logic [2*CW-1:0]  r_pp  [NA][NB];
    logic [RWW-1:0]   r_row [NA];
    logic [RWW-1:0]   n_row [NA];
    logic [PW-1:0]    r_p;
    logic [PW-1:0]    n_p;

    assign w_a = (NA*CW)'(i_a);
    assign w_b = (NB*CW)'(i_b);

    // stage 1: all digit products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= w_a[i*CW +: CW] * w_b[j*CW +: CW];
                end
            end
        end
    end

    // stage 2: one row per digit of a
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (RWW'(r_pp[i][j]) << (CW * j));
            end
        end
    end

    // stage 3: rows into the product
    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            n_p = n_p + (PW'(r_row[i]) << (CW * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
            r_p   <= n_p;
        end
    end

    assign o_p = r_p[AW+BW-1:0];

endmodule

>>> src/csc_div.sv
module csc_div #(
    parameter int NW = 132,
    parameter int DW = 66,
    parameter int QW = 66
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    // restoring divider, one quotient bit per stage; needs num < den << QW
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_d   [QW];
    wire  [DW-1:0] w_rem [QW];
    wire  [QW-1:0] w_low [QW];
    wire  [QW-1:0] w_q   [QW];
    wire  [DW-1:0] w_d   [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [DW:0] c_t;
            logic [DW:0] c_diff;
            logic        c_ge;

            if (k == 0) begin : g_first
                assign w_rem[k] = DW'(i_num[NW-1:QW]);
                assign w_low[k] = i_num[QW-1:0];
                assign w_q[k]   = '0;
                assign w_d[k]   = i_den;
            end else begin : g_next
                assign w_rem[k] = r_rem[k-1];
                assign w_low[k] = r_low[k-1];
                assign w_q[k]   = r_q[k-1];
                assign w_d[k]   = r_d[k-1];
            end

            assign c_t    = {w_rem[k], w_low[k][QW-1]};
            assign c_diff = c_t - {1'b0, w_d[k]};
            assign c_ge   = c_t >= {1'b0, w_d[k]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= c_ge ? c_diff[DW-1:0] : c_t[DW-1:0];
                    r_low[k] <= w_low[k] << 1;
                    r_q[k]   <= (w_q[k] << 1) | QW'(c_ge);
                    r_d[k]   <= w_d[k];
                end
            end
        end
    endgenerate

    assign o_quo = r_q[QW-1];

endmodule

>>> src/csc_sqrt.sv
module csc_sqrt #(
    parameter int RW = 33
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_x,
    output logic [RW-1:0]   o_root
);

    // digit-by-digit floor root, one root bit per stage
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_x    [RW];
    wire  [RW+1:0]   w_rem  [RW];
    wire  [RW-1:0]   w_root [RW];
    wire  [2*RW-1:0] w_x    [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic [RW+3:0] c_t;
            logic [RW+3:0] c_trial;
            logic [RW+3:0] c_diff;
            logic          c_ge;

            if (k == 0) begin : g_first
                assign w_rem[k]  = '0;
                assign w_root[k] = '0;
                assign w_x[k]    = i_x;
            end else begin : g_next
                assign w_rem[k]  = r_rem[k-1];
                assign w_root[k] = r_root[k-1];
                assign w_x[k]    = r_x[k-1];
            end

            assign c_t     = {w_rem[k], w_x[k][2*RW-1 -: 2]};
            assign c_trial = {2'b00, w_root[k], 2'b01};
            assign c_diff  = c_t - c_trial;
            assign c_ge    = c_t >= c_trial;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= c_ge ? c_diff[RW+1:0] : c_t[RW+1:0];
                    r_root[k] <= (w_root[k] << 1) | RW'(c_ge);
                    r_x[k]    <= w_x[k] << 2;
                end
            end
        end
    endgenerate

    assign o_root = r_root[RW-1];

endmodule

>>> src/capsule_sphere_contact_unit.sv
// Capsule against sphere contact query.
// Input channel: i_valid / o_ready carry one word: capsule base, tip and
// radius, sphere center and radius, all Q16.16. Output channel:
// o_valid / i_ready carry the unit normal (sphere toward capsule midpoint,
// NORMAL_FRAC_BITS fraction bits) and the gap depth, saturated Q16.16.
// Throughput: one word per cycle while the output queue has room. The
// pipeline depth is set by the restoring divider on the segment-interior
// distance (one quotient bit per stage) followed by the distance root
// (one root bit per stage); the normal path runs beside it and is aligned.
// A two-word output queue sits after the last stage, so new words keep
// entering while one result waits. Only when the queue holds two words
// does the whole pipeline hold still and o_ready drop; nothing is lost.
// Reset (synchronous, active low) empties all stages and the queue.
module capsule_sphere_contact_unit
    import csc_pkg::*;
#(
    parameter int COORD_WIDTH      = 32,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_base_x,
    input  logic [31:0] i_base_y,
    input  logic [31:0] i_base_z,
    input  logic [31:0] i_tip_x,
    input  logic [31:0] i_tip_y,
    input  logic [31:0] i_tip_z,
    input  logic [30:0] i_capsule_radius,
    input  logic [31:0] i_ball_x,
    input  logic [31:0] i_ball_y,
    input  logic [31:0] i_ball_z,
    input  logic [30:0] i_ball_radius,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_normal_x,
    output logic [15:0] o_normal_y,
    output logic [15:0] o_normal_z,
    output logic [31:0] o_gap_depth
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = NORMAL_FRAC_BITS;
    localparam int EW   = 2 * W + 3;
    localparam int QW1  = 2 * W + 2;
    localparam int RW1  = W + 1;
    localparam int QN   = 2 * F + 1;
    localparam int RWN  = F + 1;
    localparam int LM   = 6 + QW1 + RW1;
    localparam int LN   = QN + RWN + 1;
    localparam int L    = (LM > LN) ? LM : LN;
    localparam int NV   = 3 + L;
    localparam int DPW  = (W + 3 > 33) ? W + 3 : 33;
    localparam int NQW  = (F + 2 > 16) ? F + 2 : 16;

    localparam logic signed [DPW-1:0] DEP_MAX = DPW'(64'sd2147483647);
    localparam logic signed [DPW-1:0] DEP_MIN = DPW'(-64'sd2147483648);

    // pipeline enable and valid line
    logic          w_en;
    logic [NV-1:0] r_vld;
    logic          w_push;
    logic          w_pop;

    // input decode
    logic signed [W-1:0] c_bs [3];
    logic signed [W-1:0] c_tp [3];
    logic signed [W-1:0] c_bl [3];

    // stage 1: differences
    logic signed [W:0]   r1_ab [3];
    logic signed [W:0]   r1_ac [3];
    logic signed [W:0]   r1_bc [3];
    logic signed [W+1:0] r1_v  [3];
    logic [W-2:0]        r1_rc;
    logic [W-2:0]        r1_rb;

    // stage 2: products
    logic signed [2*W+1:0] c_pe  [3];
    logic signed [2*W+1:0] c_pff [3];
    logic signed [2*W+1:0] c_paa [3];
    logic signed [2*W+1:0] c_pbb [3];
    logic signed [2*W+3:0] c_pvv [3];
    logic signed [2*W+1:0] r2_pe [3];
    logic [2*W+1:0]        r2_ff [3];
    logic [2*W+1:0]        r2_aa [3];
    logic [2*W+1:0]        r2_bb [3];
    logic [2*W+2:0]        r2_vv [3];
    logic [2:0]            r2_vneg;
    logic                  r2_zero;
    logic [W-1:0]          r2_rsum;

    // stage 3: dot products
    logic signed [EW-1:0] r3_e;
    logic [2*W+1:0]       r3_f;
    logic [2*W+1:0]       r3_aa;
    logic [2*W+1:0]       r3_bb;
    logic [2*W+3:0]       r3_s;
    logic [2*W+2:0]       r3_vv [3];
    logic [2:0]           r3_vneg;
    logic                 r3_zero;
    logic [W-1:0]         r3_rsum;

    // distance path
    t_sel              r4_sel;
    t_sel              n4_sel;
    t_sel              w_sel_d;
    logic [2:0]        w_sel_bits;
    logic [4*W+3:0]    w_p_af;
    logic [4*W+3:0]    w_p_ee;
    logic [4*W+3:0]    r_num;
    logic [2*W+1:0]    w_f_d;
    logic [2*W+1:0]    w_quo;
    logic [2*W+1:0]    w_aa_d;
    logic [2*W+1:0]    w_bb_d;
    logic [2*W+1:0]    r_d2;
    logic [2*W+1:0]    n_d2;
    logic [W:0]        w_dist;
    logic [W-1:0]      w_rsum_d;
    logic signed [DPW-1:0] c_dep;
    logic [31:0]       r_depth;
    logic [31:0]       n_depth;
    logic [31:0]       w_depth_al;

    // normal path
    logic [2*F:0]      w_nq   [3];
    logic [F:0]        w_nr   [3];
    logic [3:0]        w_nflag;
    logic [NQW-1:0]    c_ncomp [3];
    logic [47:0]       r_norm;
    logic [47:0]       n_norm;
    logic [47:0]       w_norm_al;

    // output queue
    t_result r_fifo [2];
    t_result w_res;
    logic [1:0] r_cnt;
    logic       r_head;
    logic       w_wr_idx;

    assign w_en    = (r_cnt != 2'd2);
    assign o_ready = w_en && i_rst_n;

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    // coordinates at the configured width
    always_comb begin
        c_bs[0] = i_base_x[W-1:0];
        c_bs[1] = i_base_y[W-1:0];
        c_bs[2] = i_base_z[W-1:0];
        c_tp[0] = i_tip_x[W-1:0];
        c_tp[1] = i_tip_y[W-1:0];
        c_tp[2] = i_tip_z[W-1:0];
        c_bl[0] = i_ball_x[W-1:0];
        c_bl[1] = i_ball_y[W-1:0];
        c_bl[2] = i_ball_z[W-1:0];
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_ab[i] <= (W+1)'(c_tp[i]) - (W+1)'(c_bs[i]);
                r1_ac[i] <= (W+1)'(c_bl[i]) - (W+1)'(c_bs[i]);
                r1_bc[i] <= (W+1)'(c_bl[i]) - (W+1)'(c_tp[i]);
                r1_v[i]  <= (W+2)'(c_bs[i]) + (W+2)'(c_tp[i]) - ((W+2)'(c_bl[i]) <<< 1);
            end
            r1_rc <= i_capsule_radius[W-2:0];
            r1_rb <= i_ball_radius[W-2:0];
        end
    end

    // stage 2
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_pe[i]  = r1_ac[i] * r1_ab[i];
            c_pff[i] = r1_ab[i] * r1_ab[i];
            c_paa[i] = r1_ac[i] * r1_ac[i];
            c_pbb[i] = r1_bc[i] * r1_bc[i];
            c_pvv[i] = r1_v[i] * r1_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r2_pe[i]   <= c_pe[i];
                r2_ff[i]   <= c_pff[i];
                r2_aa[i]   <= c_paa[i];
                r2_bb[i]   <= c_pbb[i];
                r2_vv[i]   <= c_pvv[i][2*W+2:0];
                r2_vneg[i] <= r1_v[i][W+1];
            end
            r2_zero <= (r1_v[0] == '0) && (r1_v[1] == '0) && (r1_v[2] == '0);
            r2_rsum <= W'(r1_rc) + W'(r1_rb);
        end
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_e    <= EW'(r2_pe[0]) + EW'(r2_pe[1]) + EW'(r2_pe[2]);
            r3_f    <= r2_ff[0] + r2_ff[1] + r2_ff[2];
            r3_aa   <= r2_aa[0] + r2_aa[1] + r2_aa[2];
            r3_bb   <= r2_bb[0] + r2_bb[1] + r2_bb[2];
            r3_s    <= (2*W+4)'(r2_vv[0]) + (2*W+4)'(r2_vv[1]) + (2*W+4)'(r2_vv[2]);
            r3_vv   <= r2_vv;
            r3_vneg <= r2_vneg;
            r3_zero <= r2_zero;
            r3_rsum <= r2_rsum;
        end
    end

    // projection clamp: before base, past tip, or interior
    always_comb begin
        if (r3_e[EW-1] || (r3_e == '0)) begin
            n4_sel = SEL_BASE;
        end else if (r3_e >= $signed({1'b0, r3_f})) begin
            n4_sel = SEL_TIP;
        end else begin
            n4_sel = SEL_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_sel <= SEL_BASE;
        end else if (w_en) begin
            r4_sel <= n4_sel;
        end
    end

    // interior numerator |ac|^2*f - e*e
    csc_mul #(.AW(2*W+2), .BW(2*W+2)) u_mul_af (
        .i_clk (i_clk), .i_en (w_en), .i_a (r3_aa), .i_b (r3_f), .o_p (w_p_af)
    );

    csc_mul #(.AW(2*W+2), .BW(2*W+2)) u_mul_ee (
        .i_clk (i_clk), .i_en (w_en), .i_a (r3_e[2*W+1:0]), .i_b (r3_e[2*W+1:0]),
        .o_p   (w_p_ee)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num <= w_p_af - w_p_ee;
        end
    end

    csc_dly #(.WIDTH(2*W+2), .DEPTH(4)) u_dly_f (
        .i_clk (i_clk), .i_en (w_en), .i_d (r3_f), .o_q (w_f_d)
    );

    csc_div #(.NW(4*W+4), .DW(2*W+2), .QW(QW1)) u_div_mid (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_num), .i_den (w_f_d), .o_quo (w_quo)
    );

    csc_dly #(.WIDTH(2*W+2), .DEPTH(4+QW1)) u_dly_aa (
        .i_clk (i_clk), .i_en (w_en), .i_d (r3_aa), .o_q (w_aa_d)
    );

    csc_dly #(.WIDTH(2*W+2), .DEPTH(4+QW1)) u_dly_bb (
        .i_clk (i_clk), .i_en (w_en), .i_d (r3_bb), .o_q (w_bb_d)
    );

    csc_dly #(.WIDTH(3), .DEPTH(3+QW1)) u_dly_sel (
        .i_clk (i_clk), .i_en (w_en), .i_d (r4_sel), .o_q (w_sel_bits)
    );

    assign w_sel_d = t_sel'(w_sel_bits);

    // squared distance pick
    always_comb begin
        case (w_sel_d)
            SEL_BASE: n_d2 = w_aa_d;
            SEL_TIP:  n_d2 = w_bb_d;
            SEL_MID:  n_d2 = w_quo;
            default:  n_d2 = w_aa_d;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2 <= n_d2;
        end
    end

    csc_sqrt #(.RW(RW1)) u_sqrt_dist (
        .i_clk (i_clk), .i_en (w_en), .i_x (r_d2), .o_root (w_dist)
    );

    csc_dly #(.WIDTH(W), .DEPTH(5+QW1+RW1)) u_dly_rsum (
        .i_clk (i_clk), .i_en (w_en), .i_d (r3_rsum), .o_q (w_rsum_d)
    );

    // depth with saturation
    always_comb begin
        c_dep = $signed(DPW'(w_dist)) - $signed(DPW'(w_rsum_d));
        if (c_dep > DEP_MAX) begin
            n_depth = DEP_MAX[31:0];
        end else if (c_dep < DEP_MIN) begin
            n_depth = DEP_MIN[31:0];
        end else begin
            n_depth = c_dep[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_depth <= n_depth;
        end
    end

    csc_dly #(.WIDTH(32), .DEPTH(L-LM)) u_dly_depth (
        .i_clk (i_clk), .i_en (w_en), .i_d (r_depth), .o_q (w_depth_al)
    );

    // normal: root of floor(v_i^2 * 4^F / |v|^2)
    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_norm
            csc_div #(.NW(2*W+3+2*F), .DW(2*W+4), .QW(QN)) u_div_n (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num ({r3_vv[gi], {(2*F){1'b0}}}),
                .i_den (r3_s),
                .o_quo (w_nq[gi])
            );

            csc_sqrt #(.RW(RWN)) u_sqrt_n (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_x    ({1'b0, w_nq[gi]}),
                .o_root (w_nr[gi])
            );
        end
    endgenerate

    csc_dly #(.WIDTH(4), .DEPTH(QN+RWN)) u_dly_nflag (
        .i_clk (i_clk), .i_en (w_en), .i_d ({r3_zero, r3_vneg}), .o_q (w_nflag)
    );

    // sign and coincident-center case
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_ncomp[i] = w_nflag[i] ? (NQW'(0) - NQW'(w_nr[i])) : NQW'(w_nr[i]);
        end
        if (w_nflag[3]) begin
            n_norm = {16'(NQW'(1) << F), 16'd0, 16'd0};
        end else begin
            n_norm = {c_ncomp[0][15:0], c_ncomp[1][15:0], c_ncomp[2][15:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_norm <= n_norm;
        end
    end

    csc_dly #(.WIDTH(48), .DEPTH(L-LN)) u_dly_norm (
        .i_clk (i_clk), .i_en (w_en), .i_d (r_norm), .o_q (w_norm_al)
    );

    // output queue, two words
    assign w_res.normal_x  = w_norm_al[47:32];
    assign w_res.normal_y  = w_norm_al[31:16];
    assign w_res.normal_z  = w_norm_al[15:0];
    assign w_res.gap_depth = w_depth_al;

    assign w_push   = w_en && r_vld[NV-1];
    assign w_pop    = o_valid && i_ready;
    assign w_wr_idx = r_head ^ r_cnt[0];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[w_wr_idx] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
        end else begin
            r_cnt  <= r_cnt + 2'(w_push) - 2'(w_pop);
            if (w_pop) begin
                r_head <= ~r_head;
            end
        end
    end

    assign o_valid     = (r_cnt != 2'd0);
    assign o_normal_x  = r_fifo[r_head].normal_x;
    assign o_normal_y  = r_fifo[r_head].normal_y;
    assign o_normal_z  = r_fifo[r_head].normal_z;
    assign o_gap_depth = r_fifo[r_head].gap_depth;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NV-1] && !w_en) |=> r_vld[NV-1])
        else $error("last stage word lost during stall");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1 && w_pop && !w_push) |=> !o_valid)
        else $error("queue did not drain");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> (r_cnt == 2'd2 && $stable(r_vld)))
        else $error("pipeline moved while queue full");
`endif

endmodule
